[design/idp_pkg.sv]
`timescale 1ns / 1ps
// Package for the IMU data packet parser: shared types, register indexes,
// reset values and the packet group byte set. No dependencies.
package idp_pkg;

  // Parse phase of the running byte stream.
  typedef enum logic [2:0] {
    PH_STOPPED = 3'd0,
    PH_LEAD    = 3'd1,
    PH_ID_LO   = 3'd2,
    PH_SIZE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_MSG_LEN = 3'd5
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA2_MID = 3'd5;

  // Register reset values.
  localparam logic [15:0] QUAT_ID_RST   = 16'h2010;
  localparam logic [15:0] ACCEL_ID_RST  = 16'h4020;
  localparam logic [15:0] MAG_ID_RST    = 16'hC020;
  localparam logic [15:0] ROT_ID_RST    = 16'h8020;
  localparam logic [7:0]  DATA_MID_RST  = 8'h32;
  localparam logic [7:0]  DATA2_MID_RST = 8'h36;

  // Result kind codes.
  localparam logic [1:0] KIND_QUAT  = 2'd0;
  localparam logic [1:0] KIND_ACCEL = 2'd1;
  localparam logic [1:0] KIND_MAG   = 2'd2;
  localparam logic [1:0] KIND_ROT   = 2'd3;

  // Leading bytes that open a data packet.
  localparam logic [7:0] GRP_10 = 8'h10;
  localparam logic [7:0] GRP_20 = 8'h20;
  localparam logic [7:0] GRP_40 = 8'h40;
  localparam logic [7:0] GRP_80 = 8'h80;
  localparam logic [7:0] GRP_C0 = 8'hC0;
  localparam logic [7:0] GRP_E0 = 8'hE0;

  typedef struct packed {
    logic [15:0] quat_id;
    logic [15:0] accel_id;
    logic [15:0] mag_id;
    logic [15:0] rot_id;
    logic [7:0]  data_mid;
    logic [7:0]  data2_mid;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  remaining;
    logic [15:0] packet_id;
    logic [7:0]  packet_len;
    logic [7:0]  payload_pos;
    logic [23:0] word_acc;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [31:0] word;
  } result_t;

  function automatic logic is_group(logic [7:0] b);
    return (b == GRP_10) || (b == GRP_20) || (b == GRP_40) ||
           (b == GRP_80) || (b == GRP_C0) || (b == GRP_E0);
  endfunction

endpackage

[design/idp_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the IMU data packet parser: one buffer byte per word.
// Depends on nothing.
interface idp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_req;
  logic [7:0] frame_len;

  modport source (output valid, output in_byte, output start_req, output frame_len,
                  input ready);
  modport sink (input valid, input in_byte, input start_req, input frame_len,
                output ready);
endinterface

[design/idp_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the IMU data packet parser: one sensor word per word.
// Depends on nothing.
interface idp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  index;
  logic [31:0] word;

  modport source (output valid, output kind, output index, output word, input ready);
  modport sink (input valid, input kind, input index, input word, output ready);
endinterface

[design/idp_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the IMU data packet parser.
// Depends on idp_pkg.
module idp_cfg_regs
  import idp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quat_id   <= QUAT_ID_RST;
      cfg.accel_id  <= ACCEL_ID_RST;
      cfg.mag_id    <= MAG_ID_RST;
      cfg.rot_id    <= ROT_ID_RST;
      cfg.data_mid  <= DATA_MID_RST;
      cfg.data2_mid <= DATA2_MID_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUAT_ID:   cfg.quat_id   <= cfg_data;
        CFG_ACCEL_ID:  cfg.accel_id  <= cfg_data;
        CFG_MAG_ID:    cfg.mag_id    <= cfg_data;
        CFG_ROT_ID:    cfg.rot_id    <= cfg_data;
        CFG_DATA_MID:  cfg.data_mid  <= cfg_data[7:0];
        CFG_DATA2_MID: cfg.data2_mid <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[design/idp_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one buffer byte of the IMU data packet parser.
// Depends on idp_pkg.
module idp_step
  import idp_pkg::*;
(
  input  state_t     cur,
  input  cfg_t       cfg,
  input  logic [7:0] in_byte,
  input  logic       start_req,
  input  logic [7:0] frame_len,
  output state_t     nxt,
  output logic       hit,
  output result_t    res
);

  // Handling of a byte that leads a packet or a message header.
  function automatic state_t lead_byte(state_t s, logic [7:0] b, cfg_t c);
    state_t r;
    r = s;
    if (s.remaining < 8'd2) begin
      r.phase = PH_STOPPED;
    end else if (is_group(b)) begin
      r.packet_id = {b, 8'h00};
      r.remaining = s.remaining - 8'd1;
      r.phase     = PH_ID_LO;
    end else if ((b == c.data_mid) || (b == c.data2_mid)) begin
      r.phase = PH_MSG_LEN;
    end else begin
      r.phase = PH_STOPPED;
    end
    return r;
  endfunction

  state_t     loaded;
  logic [7:0] pos_inc;
  logic       id_known;
  logic [1:0] id_kind;

  // Packet id lookup; the lowest kind wins when ids are equal.
  always_comb begin
    id_known = 1'b1;
    id_kind  = KIND_QUAT;
    priority if (cur.packet_id == cfg.quat_id) id_kind = KIND_QUAT;
    else if (cur.packet_id == cfg.accel_id) id_kind = KIND_ACCEL;
    else if (cur.packet_id == cfg.mag_id) id_kind = KIND_MAG;
    else if (cur.packet_id == cfg.rot_id) id_kind = KIND_ROT;
    else id_known = 1'b0;
  end

  assign pos_inc = cur.payload_pos + 8'd1;

  // Phase transitions and word assembly.
  always_comb begin
    loaded           = cur;
    loaded.remaining = frame_len;
    nxt              = cur;
    hit              = 1'b0;
    res.kind         = id_kind;
    res.index        = cur.payload_pos[7:2];
    res.word         = {cur.word_acc, in_byte};
    if (start_req) begin
      nxt = lead_byte(loaded, in_byte, cfg);
    end else begin
      unique case (cur.phase)
        PH_STOPPED: nxt = cur;
        PH_LEAD: nxt = lead_byte(cur, in_byte, cfg);
        PH_ID_LO: begin
          nxt.packet_id = {cur.packet_id[15:8], in_byte};
          nxt.remaining = cur.remaining - 8'd1;
          nxt.phase     = PH_SIZE;
        end
        PH_SIZE: begin
          if (cur.remaining == 8'd0) begin
            nxt.phase = PH_STOPPED;
          end else begin
            nxt.remaining  = cur.remaining - 8'd1;
            nxt.packet_len = in_byte;
            if (in_byte > nxt.remaining) begin
              nxt.phase = PH_STOPPED;
            end else begin
              nxt.payload_pos = 8'd0;
              nxt.word_acc    = 24'd0;
              nxt.phase       = (in_byte == 8'd0) ? PH_LEAD : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (cur.payload_pos[1:0] == 2'b11) begin
            hit          = id_known;
            nxt.word_acc = 24'd0;
          end else begin
            nxt.word_acc = {cur.word_acc[15:0], in_byte};
          end
          nxt.payload_pos = pos_inc;
          nxt.remaining   = cur.remaining - 8'd1;
          if (pos_inc == cur.packet_len) begin
            nxt.phase = PH_LEAD;
          end
        end
        PH_MSG_LEN: begin
          nxt.remaining = in_byte;
          nxt.phase     = PH_LEAD;
        end
        default: nxt.phase = PH_STOPPED;
      endcase
    end
  end

endmodule

[design/imu_data_packet_parser_core.sv]
`timescale 1ns / 1ps
// IMU data packet parser, top level.
// A result word is valid on the output register in the cycle after its last byte is taken.
// Throughput: one byte per cycle when not stalled; the parse state register closes the loop.
// Input stalls while a finished word waits unread; a byte is taken in the cycle it drains.
// Reset (synchronous, active high) stops parsing and restores register defaults.
module imu_data_packet_parser_core
  import idp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  idp_in_if.sink                in_ch,
  idp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  logic    hit;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    accept;

  idp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  idp_step u_step (
    .cur       (state),
    .cfg       (cfg),
    .in_byte   (in_ch.in_byte),
    .start_req (in_ch.start_req),
    .frame_len (in_ch.frame_len),
    .nxt       (state_next),
    .hit       (hit),
    .res       (res)
  );

  // A byte is taken whenever the output register is free or being drained.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Parse state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_STOPPED;
      state.remaining   <= 8'd0;
      state.packet_id   <= 16'd0;
      state.packet_len  <= 8'd0;
      state.payload_pos <= 8'd0;
      state.word_acc    <= 24'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= hit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      out_res <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.kind  = out_res.kind;
  assign out_ch.index = out_res.index;
  assign out_ch.word  = out_res.word;

endmodule
